// ===== hdl/quadratic_curve_tessellator_top_assert.svh =====
// Assertion macros shared by the tessellator modules.
// Each macro expects signals named clk and rst in the module that uses it.
`ifndef QUADRATIC_CURVE_TESSELLATOR_TOP_ASSERT_SVH
`define QUADRATIC_CURVE_TESSELLATOR_TOP_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define QCT_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tessellator check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define QCT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tessellator check failed");

`endif

// ===== hdl/qct_pkg.sv =====
package qct_pkg;

  // Coordinate and arithmetic widths.
  localparam int COORD_W = 32;
  localparam int RES_W   = 6;
  localparam int DEN_W   = 2 * RES_W;
  localparam int DIFF_W  = COORD_W + 3;
  localparam int MAG_W   = COORD_W + 2;
  localparam int ACC_W   = COORD_W + 8;
  localparam int CNT_W   = $clog2(MAG_W + 1);

  // Resolution limits.
  localparam logic [RES_W-1:0] MAX_STEPS   = 6'd62;
  localparam logic [RES_W-1:0] DEFAULT_RES = 6'd5;

  // Which quotient the shared divider works on.
  typedef enum logic [1:0] {
    DIV_D1X,
    DIV_D1Y,
    DIV_D2X,
    DIV_D2Y
  } div_sel_t;

  // Which vertex goes into the output register.
  typedef enum logic [1:0] {
    EMIT_START,
    EMIT_CURVE,
    EMIT_END
  } emit_sel_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_INIT,
    ST_EMIT_START,
    ST_STEP,
    ST_EMIT_END
  } qct_state_t;

  // One curve on the input channel.
  typedef struct packed {
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] control_x;
    logic signed [COORD_W-1:0] control_y;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
  } qct_in_t;

  // One polyline vertex on the output channel.
  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic [RES_W-1:0]          vertex_number;
    logic                      last_vertex;
  } qct_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      load;
    logic      div_start;
    logic      div_store;
    div_sel_t  div_sel;
    logic      init;
    logic      emit;
    emit_sel_t emit_sel;
    logic      advance;
  } qct_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_done;
    logic last_step;
    logic out_free;
  } qct_status_t;

endpackage

// ===== hdl/qct_div.sv =====
module qct_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [qct_pkg::MAG_W-1:0]   num,
  input  logic [qct_pkg::DEN_W-1:0]   divisor,
  output logic                        done,
  output logic [qct_pkg::MAG_W-1:0]   quo,
  output logic [qct_pkg::DEN_W-1:0]   rem
);
  import qct_pkg::*;

  logic                 busy;
  logic [CNT_W-1:0]     cnt;
  logic [MAG_W-1:0]     sh;
  logic [DEN_W-1:0]     rem_r;
  logic [DEN_W-1:0]     dvs;
  logic [DEN_W:0]       trial;
  logic                 ge;
  logic [DEN_W-1:0]     rem_next;

  // One restoring step: bring down the next numerator bit and try a subtract.
  always_comb begin
    trial    = {rem_r, sh[MAG_W-1]};
    ge       = trial >= {1'b0, dvs};
    rem_next = ge ? DEN_W'(trial - {1'b0, dvs}) : DEN_W'(trial);
  end

  // Control: count down one quotient bit per cycle, pulse done at the end.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(MAG_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Operands: the shift register turns from numerator into quotient.
  always_ff @(posedge clk) begin
    if (start) begin
      sh    <= num;
      rem_r <= '0;
      dvs   <= divisor;
    end else if (busy) begin
      sh    <= {sh[MAG_W-2:0], ge};
      rem_r <= rem_next;
    end
  end

  assign quo = sh;
  assign rem = rem_r;

`include "quadratic_curve_tessellator_top_assert.svh"

  `QCT_ASSERT_IMPL(a_rem_below_divisor, busy, rem_r < dvs)

endmodule

// ===== hdl/qct_datapath.sv =====
module qct_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  input  logic [qct_pkg::RES_W-1:0]   cfg_data,
  input  qct_pkg::qct_in_t            curve_data,
  input  qct_pkg::qct_cmd_t           cmd,
  output qct_pkg::qct_status_t        status,
  input  logic                        vertex_stall,
  output logic                        vertex_valid,
  output qct_pkg::qct_out_t           vertex_data
);
  import qct_pkg::*;

  logic [RES_W-1:0]          resolution;
  logic [RES_W-1:0]          res_fixed;

  logic signed [COORD_W-1:0] in_a [2];
  logic signed [COORD_W-1:0] in_b [2];
  logic signed [COORD_W-1:0] in_c [2];
  logic signed [DIFF_W-1:0]  d1_in [2];
  logic signed [DIFF_W-1:0]  d2_in [2];

  logic signed [COORD_W-1:0] pt_a [2];
  logic signed [COORD_W-1:0] pt_c [2];
  logic signed [DIFF_W-1:0]  d1 [2];
  logic signed [DIFF_W-1:0]  d2 [2];
  logic [RES_W-1:0]          res_lat;
  logic [DEN_W-1:0]          den;

  // Floor quotients and remainders of d1 / R and d2 / R^2, per lane.
  logic signed [ACC_W-1:0]   qa1 [2];
  logic [DEN_W-1:0]          ra1 [2];
  logic signed [ACC_W-1:0]   qa2 [2];
  logic [DEN_W-1:0]          ra2 [2];

  // Running floor forms of d1*s/R, d2*s*s/R^2 and the increment d2*(2s+1)/R^2.
  logic signed [ACC_W-1:0]   acc_q1 [2];
  logic [DEN_W-1:0]          acc_r1 [2];
  logic signed [ACC_W-1:0]   acc_q2 [2];
  logic [DEN_W-1:0]          acc_r2 [2];
  logic signed [ACC_W-1:0]   inc_q [2];
  logic [DEN_W-1:0]          inc_r [2];
  logic signed [ACC_W-1:0]   dbl_q [2];
  logic [DEN_W-1:0]          dbl_r [2];
  logic [RES_W-1:0]          step;

  logic                      div_coord;
  logic                      div_kind;
  logic signed [DIFF_W-1:0]  div_num;
  logic                      div_neg;
  logic [MAG_W-1:0]          div_mag;
  logic [DEN_W-1:0]          div_dvs;
  logic                      div_done;
  logic [MAG_W-1:0]          div_quo;
  logic [DEN_W-1:0]          div_rem;
  logic signed [ACC_W-1:0]   quo_ext;
  logic signed [ACC_W-1:0]   fl_q;
  logic [DEN_W-1:0]          fl_r;

  logic [DEN_W:0]            dbl_raw [2];
  logic signed [ACC_W-1:0]   dbl_q_in [2];
  logic [DEN_W-1:0]          dbl_r_in [2];

  logic [DEN_W:0]            s1 [2];
  logic [DEN_W:0]            s2 [2];
  logic [DEN_W:0]            si [2];
  logic                      c1 [2];
  logic                      c2 [2];
  logic                      ci [2];
  logic [DEN_W-1:0]          r1_next [2];
  logic [DEN_W-1:0]          r2_next [2];
  logic [DEN_W-1:0]          ri_next [2];

  logic signed [ACC_W-1:0]   t1 [2];
  logic signed [ACC_W-1:0]   t2 [2];
  logic signed [ACC_W-1:0]   sum [2];
  logic signed [COORD_W-1:0] sat [2];
  logic signed [COORD_W-1:0] sel_pt [2];
  logic [RES_W-1:0]          vnum;

  // Resolution register: zero stores the default, values above the limit clamp.
  always_comb begin
    if (cfg_data == '0) begin
      res_fixed = DEFAULT_RES;
    end else if (cfg_data > MAX_STEPS) begin
      res_fixed = MAX_STEPS;
    end else begin
      res_fixed = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      resolution <= DEFAULT_RES;
    end else if (cfg_valid) begin
      resolution <= res_fixed;
    end
  end

  // Input lanes and the two difference terms of the curve.
  always_comb begin
    in_a[0] = curve_data.start_x;
    in_a[1] = curve_data.start_y;
    in_b[0] = curve_data.control_x;
    in_b[1] = curve_data.control_y;
    in_c[0] = curve_data.end_x;
    in_c[1] = curve_data.end_y;
    for (int i = 0; i < 2; i++) begin
      d2_in[i] = DIFF_W'(in_a[i]) - (DIFF_W'(in_b[i]) <<< 1) + DIFF_W'(in_c[i]);
      d1_in[i] = (DIFF_W'(in_b[i]) - DIFF_W'(in_a[i])) <<< 1;
    end
  end

  // Capture the curve when it is accepted.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < 2; i++) begin
        pt_a[i] <= in_a[i];
        pt_c[i] <= in_c[i];
        d1[i]   <= d1_in[i];
        d2[i]   <= d2_in[i];
      end
      res_lat <= resolution;
      den     <= DEN_W'(resolution) * DEN_W'(resolution);
    end
  end

  // Divider operand selection: magnitude of the chosen difference term.
  always_comb begin
    div_coord = (cmd.div_sel == DIV_D1Y) || (cmd.div_sel == DIV_D2Y);
    div_kind  = (cmd.div_sel == DIV_D2X) || (cmd.div_sel == DIV_D2Y);
    div_num   = div_kind ? d2[div_coord] : d1[div_coord];
    div_neg   = div_num[DIFF_W-1];
    div_mag   = MAG_W'(div_neg ? -div_num : div_num);
    div_dvs   = div_kind ? den : DEN_W'(res_lat);
  end

  qct_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.div_start),
    .num     (div_mag),
    .divisor (div_dvs),
    .done    (div_done),
    .quo     (div_quo),
    .rem     (div_rem)
  );

  // Turn the magnitude quotient into floor form with a non-negative remainder.
  always_comb begin
    quo_ext = $signed({{(ACC_W-MAG_W){1'b0}}, div_quo});
    if (div_neg && div_rem != '0) begin
      fl_q = -quo_ext - ACC_W'(1);
      fl_r = div_dvs - div_rem;
    end else if (div_neg) begin
      fl_q = -quo_ext;
      fl_r = '0;
    end else begin
      fl_q = quo_ext;
      fl_r = div_rem;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_store) begin
      if (div_kind) begin
        qa2[div_coord] <= fl_q;
        ra2[div_coord] <= fl_r;
      end else begin
        qa1[div_coord] <= fl_q;
        ra1[div_coord] <= fl_r;
      end
    end
  end

  // Per-step arithmetic: floor forms for 2*d2/R^2 and the running sums.
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      dbl_raw[i] = {ra2[i], 1'b0};
      if (dbl_raw[i] >= {1'b0, den}) begin
        dbl_q_in[i] = (qa2[i] <<< 1) + ACC_W'(1);
        dbl_r_in[i] = DEN_W'(dbl_raw[i] - {1'b0, den});
      end else begin
        dbl_q_in[i] = qa2[i] <<< 1;
        dbl_r_in[i] = DEN_W'(dbl_raw[i]);
      end

      s1[i]      = {1'b0, acc_r1[i]} + {1'b0, ra1[i]};
      c1[i]      = s1[i] >= (DEN_W+1)'(res_lat);
      r1_next[i] = c1[i] ? DEN_W'(s1[i] - (DEN_W+1)'(res_lat)) : DEN_W'(s1[i]);

      s2[i]      = {1'b0, acc_r2[i]} + {1'b0, inc_r[i]};
      c2[i]      = s2[i] >= {1'b0, den};
      r2_next[i] = c2[i] ? DEN_W'(s2[i] - {1'b0, den}) : DEN_W'(s2[i]);

      si[i]      = {1'b0, inc_r[i]} + {1'b0, dbl_r[i]};
      ci[i]      = si[i] >= {1'b0, den};
      ri_next[i] = ci[i] ? DEN_W'(si[i] - {1'b0, den}) : DEN_W'(si[i]);
    end
  end

  // Running sums, cleared at the start of the curve and advanced with each curve vertex.
  always_ff @(posedge clk) begin
    if (cmd.init) begin
      for (int i = 0; i < 2; i++) begin
        acc_q1[i] <= '0;
        acc_r1[i] <= '0;
        acc_q2[i] <= '0;
        acc_r2[i] <= '0;
        inc_q[i]  <= qa2[i];
        inc_r[i]  <= ra2[i];
        dbl_q[i]  <= dbl_q_in[i];
        dbl_r[i]  <= dbl_r_in[i];
      end
      step <= '0;
    end else if (cmd.advance) begin
      for (int i = 0; i < 2; i++) begin
        acc_q1[i] <= acc_q1[i] + qa1[i] + $signed({{(ACC_W-1){1'b0}}, c1[i]});
        acc_r1[i] <= r1_next[i];
        acc_q2[i] <= acc_q2[i] + inc_q[i] + $signed({{(ACC_W-1){1'b0}}, c2[i]});
        acc_r2[i] <= r2_next[i];
        inc_q[i]  <= inc_q[i] + dbl_q[i] + $signed({{(ACC_W-1){1'b0}}, ci[i]});
        inc_r[i]  <= ri_next[i];
      end
      step <= step + 1'b1;
    end
  end

  // Vertex value: truncate both quotients toward zero, add A, saturate.
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      t1[i]  = acc_q1[i] +
               $signed({{(ACC_W-1){1'b0}}, (d1[i][DIFF_W-1] && acc_r1[i] != '0)});
      t2[i]  = acc_q2[i] +
               $signed({{(ACC_W-1){1'b0}}, (d2[i][DIFF_W-1] && acc_r2[i] != '0)});
      sum[i] = t2[i] + t1[i] + ACC_W'(pt_a[i]);
      if (sum[i][ACC_W-1:COORD_W-1] == '0 || sum[i][ACC_W-1:COORD_W-1] == '1) begin
        sat[i] = sum[i][COORD_W-1:0];
      end else if (sum[i][ACC_W-1]) begin
        sat[i] = {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
        sat[i] = {1'b0, {(COORD_W-1){1'b1}}};
      end
      case (cmd.emit_sel)
        EMIT_START: sel_pt[i] = pt_a[i];
        EMIT_END:   sel_pt[i] = pt_c[i];
        default:    sel_pt[i] = sat[i];
      endcase
    end
    vnum = (cmd.emit_sel == EMIT_START) ? '0 : step + 1'b1;
  end

  // Output register: holds a vertex until the receiver takes the beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_valid <= 1'b0;
    end else if (cmd.emit) begin
      vertex_valid <= 1'b1;
    end else if (!vertex_stall) begin
      vertex_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      vertex_data.point_x       <= sel_pt[0];
      vertex_data.point_y       <= sel_pt[1];
      vertex_data.vertex_number <= vnum;
      vertex_data.last_vertex   <= (cmd.emit_sel == EMIT_END);
    end
  end

  // Status back to the controller.
  always_comb begin
    status.div_done  = div_done;
    status.last_step = (step == res_lat - 1'b1);
    status.out_free  = !vertex_valid || !vertex_stall;
  end

`include "quadratic_curve_tessellator_top_assert.svh"

  `QCT_ASSERT_IMPL(a_last_number, vertex_valid && vertex_data.last_vertex,
                   vertex_data.vertex_number == res_lat + 1'b1)
  `QCT_ASSERT_IMPL(a_inner_number, vertex_valid && !vertex_data.last_vertex,
                   vertex_data.vertex_number <= res_lat)

endmodule

// ===== hdl/qct_ctrl.sv =====
module qct_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   curve_valid,
  output logic                   curve_stall,
  input  qct_pkg::qct_status_t   status,
  output qct_pkg::qct_cmd_t      cmd
);
  import qct_pkg::*;

  qct_state_t state;
  qct_state_t state_next;
  div_sel_t   sel;
  div_sel_t   sel_next;
  div_sel_t   sel_succ;

  // Order in which the four quotients are taken.
  always_comb begin
    unique case (sel)
      DIV_D1X: sel_succ = DIV_D1Y;
      DIV_D1Y: sel_succ = DIV_D2X;
      DIV_D2X: sel_succ = DIV_D2Y;
      default: sel_succ = DIV_D1X;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      sel   <= DIV_D1X;
    end else begin
      state <= state_next;
      sel   <= sel_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next    = state;
    sel_next      = sel;
    cmd           = '0;
    cmd.div_sel   = sel;
    cmd.emit_sel  = EMIT_START;
    curve_stall   = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (curve_valid) begin
          cmd.load   = 1'b1;
          sel_next   = DIV_D1X;
          state_next = ST_DIV_START;
        end
      end
      ST_DIV_START: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (status.div_done) begin
          cmd.div_store = 1'b1;
          if (sel == DIV_D2Y) begin
            state_next = ST_INIT;
          end else begin
            sel_next   = sel_succ;
            state_next = ST_DIV_START;
          end
        end
      end
      ST_INIT: begin
        cmd.init   = 1'b1;
        state_next = ST_EMIT_START;
      end
      ST_EMIT_START: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_STEP;
        end
      end
      ST_STEP: begin
        cmd.emit_sel = EMIT_CURVE;
        if (status.out_free) begin
          cmd.emit    = 1'b1;
          cmd.advance = 1'b1;
          if (status.last_step) begin
            state_next = ST_EMIT_END;
          end
        end
      end
      ST_EMIT_END: begin
        cmd.emit_sel = EMIT_END;
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

`include "quadratic_curve_tessellator_top_assert.svh"

  `QCT_ASSERT_IMPL(a_emit_needs_room, cmd.emit, status.out_free)
  `QCT_ASSERT_IMPL(a_store_needs_done, cmd.div_store, status.div_done)
  `QCT_ASSERT_NEXT(a_last_step_to_end,
                   state == ST_STEP && cmd.advance && status.last_step,
                   state == ST_EMIT_END)

endmodule

// ===== hdl/quadratic_curve_tessellator_top.sv =====
// Channel   Direction  Handshake            Beat
// curve     in         curve_valid/stall    control points A, B, C
// vertex    out        vertex_valid/stall   one polyline vertex
// cfg       in         cfg_valid/ready      resolution R
//
// A curve takes four quotient runs on one shared 34-step divider, then one vertex
// per cycle
// when the output never stalls.
// The divider makes one quotient bit per cycle; R + 2 vertices come out per curve.
// Reset (rst, synchronous) sets R to 5 and empties the output register.
// A stalled vertex holds the vertex walk; a new curve is taken once the last one is queued.
module quadratic_curve_tessellator_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        curve_valid,
  output logic                        curve_stall,
  input  qct_pkg::qct_in_t            curve_data,
  output logic                        vertex_valid,
  input  logic                        vertex_stall,
  output qct_pkg::qct_out_t           vertex_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [qct_pkg::RES_W-1:0]   cfg_data
);
  import qct_pkg::*;

  qct_cmd_t    cmd;
  qct_status_t status;

  // The resolution register takes a write in any cycle.
  assign cfg_ready = 1'b1;

  qct_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .curve_valid (curve_valid),
    .curve_stall (curve_stall),
    .status      (status),
    .cmd         (cmd)
  );

  qct_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_data     (cfg_data),
    .curve_data   (curve_data),
    .cmd          (cmd),
    .status       (status),
    .vertex_stall (vertex_stall),
    .vertex_valid (vertex_valid),
    .vertex_data  (vertex_data)
  );

endmodule
